// ===== rtl/six_channel_encoder_counter_macros.svh =====
// Assertion macros used by the encoder counter checker
`ifndef SIX_CHANNEL_ENCODER_COUNTER_MACROS_SVH
`define SIX_CHANNEL_ENCODER_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sccnt_pkg.sv =====
// Shared constants, item types and control struct of the encoder counter
`default_nettype none

package sccnt_pkg;

  localparam int CHANNELS       = 6;
  localparam int COUNT_BITS     = 32;
  localparam int LEVEL_BITS     = 6;
  localparam int SLOT_BITS      = 3;
  localparam int MODE_BITS      = 2;
  localparam int OUT_COUNT_BITS = 32;

  // Only channels that have pins can be read; the rest read zero
  localparam int READ_LIMIT = (CHANNELS < LEVEL_BITS) ? CHANNELS : LEVEL_BITS;

  // Count mode codes; the unused code behaves as disabled
  localparam logic [MODE_BITS-1:0] MODE_QUAD = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EDGE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_OFF  = 2'd2;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic [LEVEL_BITS-1:0] a_levels;
    logic [LEVEL_BITS-1:0] b_levels;
    logic [SLOT_BITS-1:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] slot_count;
    logic [SLOT_BITS-1:0]      slot_echo;
  } out_item_t;

  // Per-channel update controls from the sample stage
  typedef struct packed {
    logic                 update;
    logic                 a_prev;
    logic                 a_now;
    logic                 b_now;
    logic [MODE_BITS-1:0] mode;
  } chan_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sccnt_channel.sv =====
// One encoder channel: edge detect on A and its wrapping position count
`default_nettype none

module sccnt_channel (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sccnt_pkg::chan_ctrl_t             ctrl_i,
  output logic [sccnt_pkg::COUNT_BITS-1:0]  count_o
);

  logic [sccnt_pkg::COUNT_BITS-1:0] count_d, count_q;
  logic                             a_edge;

  assign a_edge = ctrl_i.a_prev ^ ctrl_i.a_now;

  // Next count on an A edge of a sample: 1x quadrature steps up/down, edge mode always up, other modes hold
  always_comb begin
    count_d = count_q;
    if (ctrl_i.update && a_edge) begin
      unique case (ctrl_i.mode)
        sccnt_pkg::MODE_QUAD: begin
          // rising with B high or falling with B low counts up
          if (ctrl_i.a_now == ctrl_i.b_now) begin
            count_d = count_q + sccnt_pkg::COUNT_BITS'(1);
          end else begin
            count_d = count_q - sccnt_pkg::COUNT_BITS'(1);
          end
        end
        sccnt_pkg::MODE_EDGE: count_d = count_q + sccnt_pkg::COUNT_BITS'(1);
        default:              count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== rtl/six_channel_encoder_counter.sv =====
// Top level of the six-channel encoder counter: item stages, mode register, read mux
// Usage:
//   Input channel in_valid_i/in_ready_o/in_item_i carries one item: a pin
//   sample (A and B levels of all six channels) or a read of one channel.
//   A sample updates the counts and gives no result; a read gives one
//   result item on out_valid_o/out_ready_i/out_item_o with the count and
//   the slot it answers (slots 6 and 7 read zero).
//   cfg_we_i writes cfg_wdata_i into the count mode register at once:
//   0 quadrature 1x, 1 every A edge, 2 or 3 disabled.
// Timing:
//   One item per cycle unless a read waits on a full output. An item is
//   held in the input register and processed from there; a read result
//   then goes to the output register and onto out_valid_o. Items are
//   handled in order, so a read sees every sample accepted before it.
//   When the receiver stalls, a pending result holds in the output
//   register; samples keep flowing, and a read waits in the input
//   register, which then drops in_ready_o.
// Reset:
//   rst_ni clears counts, the previous A levels (first sample compares
//   against all low), the mode (quadrature) and both valid flags.
`default_nettype none

module six_channel_encoder_counter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sccnt_pkg::MODE_BITS-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sccnt_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sccnt_pkg::out_item_t             out_item_o
);

  logic [sccnt_pkg::MODE_BITS-1:0]  mode_q;
  logic                             in_valid_q;
  sccnt_pkg::in_item_t              in_item_q;
  logic                             out_valid_q;
  sccnt_pkg::out_item_t             out_item_q;
  logic [sccnt_pkg::LEVEL_BITS-1:0] prev_a_q;

  logic                             out_free;
  logic                             advance;
  logic                             is_read;
  logic                             do_sample;
  logic                             slot_ok;
  logic [sccnt_pkg::COUNT_BITS-1:0] counts [sccnt_pkg::CHANNELS];
  logic [sccnt_pkg::COUNT_BITS-1:0] rd_count;

  // Handshake: the staged item moves on unless a read meets a full output
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_read    = (in_item_q.operation == sccnt_pkg::OP_READ);
  assign advance    = in_valid_q && (!is_read || out_free);
  assign do_sample  = advance && !is_read;
  assign in_ready_o = !in_valid_q || advance;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sccnt_pkg::MODE_QUAD;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Previous A levels, updated by every sample in any mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= '0;
    end else if (do_sample) begin
      prev_a_q <= in_item_q.a_levels;
    end
  end

  // Channel counters; channels without pins see constant low levels
  for (genvar ch = 0; ch < sccnt_pkg::CHANNELS; ch++) begin : g_chan
    sccnt_pkg::chan_ctrl_t ctrl;

    if (ch < sccnt_pkg::LEVEL_BITS) begin : g_pins
      assign ctrl.a_prev = prev_a_q[ch];
      assign ctrl.a_now  = in_item_q.a_levels[ch];
      assign ctrl.b_now  = in_item_q.b_levels[ch];
    end else begin : g_nopins
      assign ctrl.a_prev = 1'b0;
      assign ctrl.a_now  = 1'b0;
      assign ctrl.b_now  = 1'b0;
    end
    assign ctrl.update = do_sample;
    assign ctrl.mode   = mode_q;

    sccnt_channel u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_o (counts[ch])
    );
  end

  // Read mux: slots without a channel read zero
  assign slot_ok = ({1'b0, in_item_q.read_slot} <
                    (sccnt_pkg::SLOT_BITS + 1)'(sccnt_pkg::READ_LIMIT));

  always_comb begin
    rd_count = '0;
    for (int i = 0; i < sccnt_pkg::CHANNELS; i++) begin
      if (slot_ok && (in_item_q.read_slot == sccnt_pkg::SLOT_BITS'(i))) begin
        rd_count = counts[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_read) begin
      out_item_q.slot_count <= sccnt_pkg::OUT_COUNT_BITS'(rd_count);
      out_item_q.slot_echo  <= in_item_q.read_slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/sccnt_checker.sv =====
// Port-level checker for the encoder counter, bound to the top level
`default_nettype none
`include "six_channel_encoder_counter_macros.svh"

module sccnt_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_o,
  input  sccnt_pkg::in_item_t              in_item_i,
  input  logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  sccnt_pkg::out_item_t             out_item_o
);

  logic read_acc;
  logic stalled;

  assign read_acc = in_valid_i && in_ready_o &&
                    (in_item_i.operation == sccnt_pkg::OP_READ);
  assign stalled  = out_valid_o && !out_ready_i;

  // A stalled result holds its value
  `SCC_ASSERT_NXT(a_out_hold, stalled, out_valid_o && $stable(out_item_o),
                  "stalled result changed or dropped")

  // A new result only follows an accepted read
  `SCC_ASSERT_NOW(a_out_cause, $rose(out_valid_o), $past(read_acc, 2),
                  "result without a preceding read")

  // Slots without a channel read zero
  `SCC_ASSERT_NOW(a_empty_slot,
                  out_valid_o && (out_item_o.slot_echo == 3'd6 ||
                                  out_item_o.slot_echo == 3'd7),
                  out_item_o.slot_count == '0,
                  "empty slot read nonzero")

  // With the output empty the block always takes an item
  `SCC_ASSERT_NOW(a_ready_free, !out_valid_o, in_ready_o,
                  "input stalled with empty output")

endmodule

bind six_channel_encoder_counter sccnt_checker u_sccnt_checker (.*);

`default_nettype wire
